/* design/msqs_pkg.sv */
package msqs_pkg;

  localparam int NUM_QUEUES_DEF  = 4;
  localparam int FIFO_DEPTH_DEF  = 16;
  localparam int STAMP_WIDTH_DEF = 16;

  localparam int CFG_QUEUES = 4;
  localparam int CFG_QW     = 2;
  localparam int WAIT_W     = 15;
  localparam int GAIN_W     = 16;
  localparam int OP_W       = 2;
  localparam int QI_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_ONE   = 256;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BASE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END       = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_DROP    = 2'd1,
    OP_REQUEST = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // signed slack holds wait_limit minus an unsigned age
  function automatic int slack_width(int stamp_w);
    return (stamp_w + 1 > WAIT_W + 1) ? stamp_w + 1 : WAIT_W + 1;
  endfunction

  function automatic int key_width(int stamp_w);
    return slack_width(stamp_w) + GAIN_W + 1;
  endfunction

endpackage

/* design/max_wait_slack_queue_scheduler.sv */
// Max-wait slack queue scheduler for one output port.
// Input channel in_*: one command item per handshake (insert, drop newest,
// request next queue). Result channel out_*: exactly one result item per
// command, in order. Config channel cfg_*: register writes, always ready;
// write only while no command is in flight.
// Insert and drop: executed in S_EXEC; the result is loaded in S_RESP.
// Request: scans the queues one at a time through a single stamp memory
// read port and one shared key multiplier; an empty queue visits only S_RD,
// a busy queue S_RD, S_KEY and S_CMP; then S_POP serves the winner and
// S_RESP loads the result.
// One command is processed at a time; in_tready is high only when idle,
// so a new command is not taken before the last result is loaded.
// A finished result sits in the output register; if the receiver stalls,
// the block holds the next result until that register drains.
// Reset empties all queues, zeroes the served counter and loads the
// default wait limits (0) and gains (1.0). Stamp memory is not cleared.
module max_wait_slack_queue_scheduler
  import msqs_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF,
  parameter int STAMP_WIDTH = STAMP_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [1:0] op, [3:2] queue_index
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [1:0] status, [3:2] granted_queue
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int AW = QW + PW;
  localparam int KW = key_width(STAMP_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_RD, S_KEY, S_CMP, S_POP, S_RESP
  } state_t;

  state_t                 state_r;
  logic [OP_W-1:0]        op_r;
  logic [QI_W-1:0]        qi_r;
  logic [PW-1:0]          head_r [NUM_QUEUES];
  logic [CW-1:0]          fill_r [NUM_QUEUES];
  logic [STAMP_WIDTH-1:0] cnt_r;
  logic [WAIT_W-1:0]      wait_r [CFG_QUEUES];
  logic [GAIN_W-1:0]      gain_r [CFG_QUEUES];
  logic [QW-1:0]          qc_r;
  logic [QW-1:0]          win_r;
  logic                   found_r;
  logic signed [KW-1:0]   best_r;
  status_t                res_status_r;
  logic [QW-1:0]          res_grant_r;
  logic                   out_valid_r;
  status_t                out_status_r;
  logic [QI_W-1:0]        out_grant_r;

  logic                   qi_ok;
  logic [QW-1:0]          qi_q;
  logic                   q_full;
  logic [CW:0]            slot_sum;
  logic [PW-1:0]          slot;
  logic                   last_q;
  logic                   mem_we;
  logic                   mem_re;
  logic [STAMP_WIDTH-1:0] mem_rdata;
  logic signed [KW-1:0]   key;
  logic [PW-1:0]          head_inc;
  logic                   resp_load;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {4'b0, out_grant_r, out_status_r};

  assign qi_ok    = ({1'b0, qi_r} < (QI_W+1)'(NUM_QUEUES));
  assign qi_q     = qi_r[QW-1:0];
  assign q_full   = (fill_r[qi_q] >= CW'(FIFO_DEPTH));
  assign slot_sum = (CW+1)'(head_r[qi_q]) + (CW+1)'(fill_r[qi_q]);
  assign slot     = (slot_sum >= (CW+1)'(FIFO_DEPTH)) ?
                    PW'(slot_sum - (CW+1)'(FIFO_DEPTH)) : PW'(slot_sum);
  assign last_q   = (qc_r == QW'(NUM_QUEUES - 1));
  assign head_inc = (head_r[win_r] == PW'(FIFO_DEPTH - 1)) ? '0 : head_r[win_r] + 1'b1;
  assign resp_load = (state_r == S_RESP) && (!out_valid_r || out_tready);

  assign mem_we = (state_r == S_EXEC) && (op_r == OP_INSERT) && qi_ok && !q_full;
  assign mem_re = (state_r == S_RD) && (fill_r[qc_r] != '0);

  msqs_stamp_mem #(
    .DATA_W (STAMP_WIDTH),
    .ADDR_W (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   ({qi_q, slot}),
    .wdata   (cnt_r),
    .re      (mem_re),
    .raddr   ({qc_r, head_r[qc_r]}),
    .rdata_r (mem_rdata)
  );

  msqs_key_unit #(
    .STAMP_W (STAMP_WIDTH)
  ) u_key (
    .clk        (clk),
    .load       (state_r == S_KEY),
    .stamp      (mem_rdata),
    .counter    (cnt_r),
    .wait_limit (wait_r[CFG_QW'(qc_r)]),
    .gain       (gain_r[CFG_QW'(qc_r)]),
    .key_r      (key)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_QUEUES; i++) begin
        wait_r[i] <= '0;
        gain_r[i] <= GAIN_RESET;
      end
    end else if (cfg_valid) begin
      if (cfg_index < CFG_GAIN_BASE) begin
        wait_r[CFG_QW'(cfg_index - CFG_WAIT_BASE)] <= cfg_data[WAIT_W-1:0];
      end else if (cfg_index < CFG_END) begin
        gain_r[CFG_QW'(cfg_index - CFG_GAIN_BASE)] <= cfg_data[GAIN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      if (resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= in_tdata[OP_W-1:0];
            qi_r    <= in_tdata[OP_W+QI_W-1:OP_W];
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_grant_r <= '0;
          case (op_r)
            OP_INSERT: begin
              state_r <= S_RESP;
              if (!qi_ok) begin
                res_status_r <= ST_EMPTY;
              end else if (q_full) begin
                res_status_r <= ST_FULL;
              end else begin
                fill_r[qi_q] <= fill_r[qi_q] + 1'b1;
                res_status_r <= ST_OK;
              end
            end
            OP_DROP: begin
              state_r <= S_RESP;
              if (qi_ok && (fill_r[qi_q] != '0)) begin
                fill_r[qi_q] <= fill_r[qi_q] - 1'b1;
                res_status_r <= ST_OK;
              end else begin
                res_status_r <= ST_EMPTY;
              end
            end
            OP_REQUEST: begin
              qc_r    <= '0;
              found_r <= 1'b0;
              state_r <= S_RD;
            end
            default: begin
              res_status_r <= ST_EMPTY;
              state_r      <= S_RESP;
            end
          endcase
        end
        S_RD: begin
          if (fill_r[qc_r] != '0) begin
            state_r <= S_KEY;
          end else if (last_q) begin
            state_r <= S_POP;
          end else begin
            qc_r <= qc_r + 1'b1;
          end
        end
        S_KEY: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (!found_r || (key < best_r)) begin
            found_r <= 1'b1;
            best_r  <= key;
            win_r   <= qc_r;
          end
          if (last_q) begin
            state_r <= S_POP;
          end else begin
            qc_r    <= qc_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_POP: begin
          if (found_r) begin
            head_r[win_r] <= head_inc;
            fill_r[win_r] <= fill_r[win_r] - 1'b1;
            cnt_r         <= cnt_r + 1'b1;
            res_status_r  <= ST_OK;
            res_grant_r   <= win_r;
          end else begin
            res_status_r <= ST_EMPTY;
            res_grant_r  <= '0;
          end
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (resp_load) begin
            out_status_r <= res_status_r;
            out_grant_r  <= QI_W'(res_grant_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[0] <= CW'(FIFO_DEPTH))
    else $error("queue 0 fill count above depth");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> (out_grant_r == '0))
    else $error("granted queue set on a failed command");

  a_cnt_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) && !found_r |=> $stable(cnt_r))
    else $error("served counter moved without a grant");

  a_resp_before_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) && (!out_valid_r || out_tready) |=> out_valid_r && in_tready)
    else $error("result not loaded when leaving response state");

endmodule

/* design/msqs_stamp_mem.sv */
module msqs_stamp_mem #(
  parameter int DATA_W = 16,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata_r
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* design/msqs_key_unit.sv */
module msqs_key_unit
  import msqs_pkg::*;
#(
  parameter int STAMP_W = STAMP_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   load,
  input  logic [STAMP_W-1:0]                     stamp,
  input  logic [STAMP_W-1:0]                     counter,
  input  logic [WAIT_W-1:0]                      wait_limit,
  input  logic [GAIN_W-1:0]                      gain,
  output logic signed [key_width(STAMP_W)-1:0]   key_r
);

  localparam int SLW = slack_width(STAMP_W);
  localparam int KW  = key_width(STAMP_W);

  logic [STAMP_W-1:0]      age;
  logic signed [SLW-1:0]   slack;
  logic signed [GAIN_W:0]  factor;
  logic signed [KW-1:0]    product;

  assign age   = counter - stamp;
  assign slack = $signed({{(SLW-WAIT_W){1'b0}}, wait_limit})
               - $signed({{(SLW-STAMP_W){1'b0}}, age});

  // overdue queues (slack at or below zero) take their own gain, others a gain of one
  always_comb begin
    if (slack[SLW-1] || (slack == '0)) begin
      factor = $signed({1'b0, gain});
    end else begin
      factor = $signed((GAIN_W+1)'(GAIN_ONE));
    end
  end

  assign product = slack * factor;

  always_ff @(posedge clk) begin
    if (load) begin
      key_r <= product;
    end
  end

endmodule
